@@ design/wwse_pkg.sv @@
// shared types, constants and defaults for the weight window statistics block
`default_nettype none
package wwse_pkg;

	// default sizes handed to the top level parameters
	localparam int RING_DEPTH_DEF    = 64;
	localparam int WINDOW_LENGTH_DEF = 16;

	// fixed field widths
	localparam int SAMPLE_W  = 24;
	localparam int CFG_W     = 28;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NECTAR_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONS_MIN   = 2'd2;

	// event codes
	localparam logic [2:0] EV_NORMAL   = 3'd0;
	localparam logic [2:0] EV_SUDDEN   = 3'd1;
	localparam logic [2:0] EV_NECTAR   = 3'd2;
	localparam logic [2:0] EV_LOW_FOOD = 3'd3;
	localparam logic [2:0] EV_SWARM    = 3'd4;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_PREP1,
		ST_PREP2,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_RATE_GO,
		ST_RATE_WAIT,
		ST_FINISH
	} state_t;

	// operand selection for the shared divider
	typedef enum logic [1:0] {
		OP_VAR,
		OP_MEAN,
		OP_RATE
	} op_t;

	// controller to datapath commands
	typedef struct packed {
		logic clr_en;
		logic accept;
		logic walk_start;
		logic rd_en;
		logic prep1;
		logic prep2;
		logic div_start;
		logic sq_start;
		logic capture;
		op_t  op;
		logic load_out;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_done;
		logic n_zero;
		logic n_multi;
		logic div_busy;
		logic sq_busy;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

@@ design/weight_window_statistics_events.sv @@
// top level of the weight window statistics and event block
//
// Each accepted sample word is stored in a ring of RING_DEPTH entries and the
// newest WINDOW_LENGTH entries (all RING_DEPTH if fewer), in ring order, are
// reduced to count, min, max, mean, standard deviation and rate, followed by
// trend, inflow, consumption, health, anomaly score and one event code per
// result word. One sample is processed at a time: the ring walk, then a
// variance pass of the shared one-bit-per-cycle divider, a square root, a
// mean pass and a rate pass of the divider, and then the result word is
// loaded. No new sample is taken until that word is loaded. A window with one
// valid sample skips the rate pass and an empty window skips all passes. A
// result word waiting on the output holds the next one in its last state.
// After reset a clearing pass zeroes the ring before the first sample is
// taken; configuration writes are taken at any time and should be issued
// while idle.
`default_nettype none
module weight_window_statistics_events import wwse_pkg::*; #(
	parameter int RING_DEPTH    = RING_DEPTH_DEF,
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [2:0]                      event_code,
	output logic signed [27:0]              avg_weight,
	output logic [26:0]                     spread_weight,
	output logic signed [23:0]              low_weight,
	output logic signed [23:0]              high_weight,
	output logic signed [28:0]              change_rate,
	output logic signed [7:0]               trend_hundredths,
	output logic [27:0]                     inflow_rate,
	output logic [27:0]                     usage_rate,
	output logic [9:0]                      health_tenths,
	output logic [2:0]                      anomaly_tenths,
	output logic [4:0]                      valid_count,
	input  wire logic                       wr_en,
	input  wire logic [CFG_IDX_W-1:0]       wr_index,
	input  wire logic [CFG_W-1:0]           wr_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	wwse_ctrl #(
		.RING_DEPTH    (RING_DEPTH),
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and arithmetic
	wwse_datapath #(
		.RING_DEPTH    (RING_DEPTH),
		.WINDOW_LENGTH (WINDOW_LENGTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.sample           (sample),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_code       (event_code),
		.avg_weight       (avg_weight),
		.spread_weight    (spread_weight),
		.low_weight       (low_weight),
		.high_weight      (high_weight),
		.change_rate      (change_rate),
		.trend_hundredths (trend_hundredths),
		.inflow_rate      (inflow_rate),
		.usage_rate       (usage_rate),
		.health_tenths    (health_tenths),
		.anomaly_tenths   (anomaly_tenths),
		.valid_count      (valid_count)
	);

endmodule
`default_nettype wire

@@ design/wwse_div.sv @@
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module wwse_div import wwse_pkg::*; #(
	parameter int DW  = 64,
	parameter int DNW = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [DW-1:0]          numer,
	input  wire logic [DNW-1:0]         denom,
	input  wire logic [$clog2(DW+1)-1:0] count,
	output logic                        busy,
	output logic [DW-1:0]               quo,
	output logic                        rem_nz
);

	localparam int KW = $clog2(DW+1);
	localparam int IW = $clog2(DW);

	logic [KW-1:0]  cnt_q;
	logic [DW-1:0]  numer_q;
	logic [DNW-1:0] den_q;
	logic [DNW-1:0] rem_q;
	logic [DW-1:0]  quo_q;
	logic [KW-1:0]  idx_full;
	logic [DNW:0]   trial;
	logic           fits;

	// next numerator bit shifted into the partial remainder
	assign idx_full = cnt_q - KW'(1);
	assign trial    = {rem_q, numer_q[idx_full[IW-1:0]]};
	assign fits     = trial >= {1'b0, den_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= count;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - KW'(1);
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			numer_q <= numer;
			den_q   <= denom;
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DNW'(trial - {1'b0, den_q}) : trial[DNW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy   = cnt_q != '0;
	assign quo    = quo_q;
	assign rem_nz = rem_q != '0;

endmodule
`default_nettype wire

@@ design/wwse_sqrt.sv @@
// serial integer square root, two radicand bits per cycle
`default_nettype none
module wwse_sqrt import wwse_pkg::*; #(
	parameter int SQW = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SQW-1:0]     radicand,
	output logic                    busy,
	output logic [SQW/2-1:0]        root
);

	logic [SQW-1:0] x_q;
	logic [SQW-1:0] r_q;
	logic [SQW-1:0] b_q;
	logic [SQW:0]   trial;
	logic           fits;

	assign trial = (SQW+1)'(r_q) + (SQW+1)'(b_q);
	assign fits  = (SQW+1)'(x_q) >= trial;

	// bit marker walks down two places a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (start) begin
			b_q <= SQW'(1) << (SQW-2);
		end else begin
			b_q <= b_q >> 2;
		end
	end

	// remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			r_q <= '0;
		end else if (b_q != '0) begin
			if (fits) begin
				x_q <= x_q - trial[SQW-1:0];
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign busy = b_q != '0;
	assign root = r_q[SQW/2-1:0];

endmodule
`default_nettype wire

@@ design/wwse_datapath.sv @@
// sample ring, window accumulators, divide and root units and result logic
`default_nettype none
module wwse_datapath import wwse_pkg::*; #(
	parameter int RING_DEPTH    = RING_DEPTH_DEF,
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire cmd_t                        cmd,
	output sts_t                             sts,
	input  wire logic signed [SAMPLE_W-1:0]  sample,
	input  wire logic                        wr_en,
	input  wire logic [CFG_IDX_W-1:0]        wr_index,
	input  wire logic [CFG_W-1:0]            wr_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [2:0]                       event_code,
	output logic signed [27:0]               avg_weight,
	output logic [26:0]                      spread_weight,
	output logic signed [23:0]               low_weight,
	output logic signed [23:0]               high_weight,
	output logic signed [28:0]               change_rate,
	output logic signed [7:0]                trend_hundredths,
	output logic [27:0]                      inflow_rate,
	output logic [27:0]                      usage_rate,
	output logic [9:0]                       health_tenths,
	output logic [2:0]                       anomaly_tenths,
	output logic [4:0]                       valid_count
);

	localparam int WIN  = (WINDOW_LENGTH < RING_DEPTH) ? WINDOW_LENGTH : RING_DEPTH;
	localparam int AW   = $clog2(RING_DEPTH);
	localparam int CW   = $clog2(WIN+1);
	localparam int SUMW = SAMPLE_W + CW + 1;
	localparam int SQQW = 2*SAMPLE_W - 1;
	localparam int SQSW = SQQW + CW;
	localparam int P1W  = SQSW + CW;
	localparam int P2W  = 2*SUMW;
	localparam int EW   = ((P1W > P2W) ? P1W : P2W) + 1;
	localparam int VNW  = P1W + 8;
	localparam int MNW  = SUMW + 6;
	localparam int RNW  = 35;
	localparam int DW0  = (VNW > MNW) ? VNW : MNW;
	localparam int DW   = (DW0 > RNW) ? DW0 : RNW;
	localparam int DNA  = 2*CW;
	localparam int DNB  = $clog2(2*WINDOW_LENGTH+1);
	localparam int DNW  = (DNA > DNB) ? DNA : DNB;
	localparam int KW   = $clog2(DW+1);
	localparam int SQW  = DW + (DW % 2);
	localparam int RTW  = SQW/2;
	localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH-1);
	localparam logic signed [DW:0] RMAX = (DW+1)'(268435455);
	localparam logic signed [DW:0] RMIN = -(DW+1)'(268435456);

	// ring storage and pointers
	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       clr_addr_q;
	logic [AW-1:0]       rd_addr_q;
	logic [AW:0]         wp_ext;
	logic [AW:0]         start_addr;

	// walk pipeline
	logic [SAMPLE_W-1:0]        rd_data_s1;
	logic                       vld_s1;
	logic signed [SAMPLE_W-1:0] v_s2;
	logic [SQQW-1:0]            sq_s2;
	logic                       vld_s2;
	logic signed [2*SAMPLE_W-1:0] sq_full;

	// accumulators
	logic [CW-1:0]              n_q;
	logic signed [SUMW-1:0]     sum_q;
	logic [SQSW-1:0]            sumsq_q;
	logic signed [SAMPLE_W-1:0] mn_q;
	logic signed [SAMPLE_W-1:0] mx_q;
	logic signed [SAMPLE_W-1:0] first_q;
	logic signed [SAMPLE_W-1:0] last_q;

	// preparation registers
	logic [P1W-1:0]        p1_q;
	logic signed [P2W-1:0] p2_q;
	logic signed [EW-1:0]  d_full;
	logic [VNW-1:0]        vnum_q;
	logic signed [MNW:0]   mnum;
	logic [MNW-1:0]        mmag_q;
	logic                  mneg_q;
	logic signed [RNW:0]   rnum;
	logic [RNW-1:0]        rmag_q;
	logic                  rneg_q;

	// divider and root
	logic [DW-1:0]  div_numer;
	logic [DNW-1:0] div_denom;
	logic [KW-1:0]  div_count;
	logic           div_busy;
	logic [DW-1:0]  div_quo;
	logic           div_nz;
	logic           sq_busy;
	logic [RTW-1:0] std_w;
	logic           res_neg;
	logic signed [DW:0] sres;

	// results
	logic signed [27:0] mean_q;
	logic signed [28:0] rate_q;
	logic [CFG_W-1:0]   thr_q;
	logic [CFG_W-1:0]   nectar_q;
	logic [CFG_W-1:0]   consmin_q;
	logic               out_valid_q;

	// finishing logic
	logic signed [29:0] rate_x;
	logic signed [29:0] thr_x;
	logic signed [29:0] neg_rate;
	logic signed [29:0] trend_x;
	logic [27:0]        inflow_c;
	logic [27:0]        cons_c;
	logic signed [7:0]  trend_c;
	logic [13:0]        stab_c;
	logic [28:0]        ic_sum;
	logic [13:0]        act_c;
	logic [14:0]        hsum;
	logic [2:0]         anom_c;
	logic [2:0]         ev_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= CFG_W'(16);
			nectar_q  <= CFG_W'(16);
			consmin_q <= CFG_W'(16);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CHANGE_THR: thr_q     <= wr_data;
				REG_NECTAR_MIN: nectar_q  <= wr_data;
				REG_CONS_MIN:   consmin_q <= wr_data;
				default: ;
			endcase
		end
	end

	// first entry of the window, in ring order
	assign wp_ext     = {1'b0, wp_q};
	assign start_addr = (wp_ext >= (AW+1)'(WIN)) ? wp_ext - (AW+1)'(WIN)
		: wp_ext + (AW+1)'(RING_DEPTH - WIN);

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			clr_addr_q <= '0;
			rd_addr_q  <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_addr_q <= (clr_addr_q == LAST_ADDR) ? '0 : clr_addr_q + AW'(1);
			end
			if (cmd.accept) begin
				wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + AW'(1);
			end
			if (cmd.walk_start) begin
				rd_addr_q <= start_addr[AW-1:0];
			end else if (cmd.rd_en) begin
				rd_addr_q <= (rd_addr_q == LAST_ADDR) ? '0 : rd_addr_q + AW'(1);
			end
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
		end
	end

	// ring memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			ring_mem[clr_addr_q] <= '0;
		end else if (cmd.accept) begin
			ring_mem[wp_q] <= sample;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= ring_mem[rd_addr_q];
		end
	end

	// square stage
	assign sq_full = $signed(rd_data_s1) * $signed(rd_data_s1);

	always_ff @(posedge clk) begin
		v_s2  <= $signed(rd_data_s1);
		sq_s2 <= sq_full[SQQW-1:0];
	end

	// window accumulators over valid samples
	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			n_q     <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
			mn_q    <= '0;
			mx_q    <= '0;
			first_q <= '0;
			last_q  <= '0;
		end else if (vld_s2 && v_s2 != '0) begin
			if (n_q == '0) begin
				mn_q    <= v_s2;
				mx_q    <= v_s2;
				first_q <= v_s2;
			end else begin
				if (v_s2 < mn_q) mn_q <= v_s2;
				if (v_s2 > mx_q) mx_q <= v_s2;
			end
			last_q  <= v_s2;
			sum_q   <= sum_q + SUMW'(v_s2);
			sumsq_q <= sumsq_q + SQSW'(sq_s2);
			n_q     <= n_q + CW'(1);
		end
	end

	// products for the variance numerator
	always_ff @(posedge clk) begin
		if (cmd.prep1) begin
			p1_q <= P1W'(sumsq_q) * P1W'(n_q);
			p2_q <= P2W'(sum_q) * P2W'(sum_q);
		end
	end

	// numerators and signs for the three divisions
	assign d_full = $signed(EW'(p1_q)) - EW'(p2_q);
	assign mnum   = ((MNW+1)'(sum_q) <<< 5) + $signed((MNW+1)'(n_q));
	assign rnum   = ((RNW+1)'(last_q) - (RNW+1)'(first_q)) * (RNW+1)'(320)
		+ (RNW+1)'(WINDOW_LENGTH);

	always_ff @(posedge clk) begin
		if (cmd.prep2) begin
			vnum_q <= (d_full < 0) ? '0 : {d_full[P1W-1:0], 8'h00};
			mneg_q <= mnum[MNW];
			mmag_q <= mnum[MNW] ? MNW'(-mnum) : MNW'(mnum);
			rneg_q <= rnum[RNW];
			rmag_q <= rnum[RNW] ? RNW'(-rnum) : RNW'(rnum);
		end
	end

	// divider operand selection
	always_comb begin
		unique case (cmd.op)
			OP_VAR: begin
				div_numer = DW'(vnum_q);
				div_denom = DNW'(n_q) * DNW'(n_q);
				div_count = KW'(VNW);
				res_neg   = 1'b0;
			end
			OP_MEAN: begin
				div_numer = DW'(mmag_q);
				div_denom = DNW'(n_q) << 1;
				div_count = KW'(MNW);
				res_neg   = mneg_q;
			end
			OP_RATE: begin
				div_numer = DW'(rmag_q);
				div_denom = DNW'(2*WINDOW_LENGTH);
				div_count = KW'(RNW);
				res_neg   = rneg_q;
			end
			default: begin
				div_numer = '0;
				div_denom = '0;
				div_count = '0;
				res_neg   = 1'b0;
			end
		endcase
	end

	wwse_div #(
		.DW  (DW),
		.DNW (DNW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (div_numer),
		.denom  (div_denom),
		.count  (div_count),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem_nz (div_nz)
	);

	wwse_sqrt #(
		.SQW (SQW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (SQW'(div_quo)),
		.busy     (sq_busy),
		.root     (std_w)
	);

	// floor quotient with sign restored
	assign sres = res_neg ? -((DW+1)'(div_quo) + (DW+1)'(div_nz)) : $signed((DW+1)'(div_quo));

	// mean and saturated rate
	always_ff @(posedge clk) begin
		if (cmd.prep2) begin
			mean_q <= '0;
			rate_q <= '0;
		end else if (cmd.capture) begin
			if (cmd.op == OP_MEAN) begin
				mean_q <= sres[27:0];
			end else if (cmd.op == OP_RATE) begin
				if (sres > RMAX)      rate_q <= 29'(RMAX);
				else if (sres < RMIN) rate_q <= 29'(RMIN);
				else                  rate_q <= sres[28:0];
			end
		end
	end

	// inflow, consumption and trend
	assign rate_x   = 30'(rate_q);
	assign thr_x    = $signed({2'b00, thr_q});
	assign neg_rate = -rate_x;
	assign trend_x  = (rate_x + 30'sd8) >>> 4;
	assign inflow_c = (rate_x > thr_x) ? rate_q[27:0] : '0;
	assign cons_c   = (rate_x < -thr_x)
		? ((neg_rate > 30'sd268435455) ? 28'hFFFFFFF : neg_rate[27:0]) : '0;
	assign trend_c  = (trend_x > 30'sd100) ? 8'sd100
		: (trend_x < -30'sd100) ? -8'sd100 : trend_x[7:0];

	// health and anomaly scores
	assign stab_c = (std_w >= RTW'(160)) ? '0 : 14'd16000 - 14'(std_w[7:0]) * 14'd100;
	assign ic_sum = 29'(inflow_c) + 29'(cons_c);
	assign act_c  = (ic_sum >= 29'd160) ? 14'd16000 : 14'(ic_sum[7:0]) * 14'd100;
	assign hsum   = 15'(stab_c) + 15'(act_c) + 15'd16;
	assign anom_c = ((std_w > RTW'(80)) ? 3'd3 : 3'd0)
		+ ((rate_q > 29'sd16 || rate_q < -29'sd16) ? 3'd4 : 3'd0);

	// event priority
	always_comb begin
		if (anom_c == 3'd7)                    ev_c = EV_SUDDEN;
		else if (inflow_c > nectar_q)          ev_c = EV_NECTAR;
		else if (cons_c > consmin_q)           ev_c = EV_LOW_FOOD;
		else if (rate_q < -29'sd800)           ev_c = EV_SWARM;
		else                                   ev_c = EV_NORMAL;
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			low_weight  <= mn_q;
			high_weight <= mx_q;
			valid_count <= 5'(n_q);
			if (n_q == '0) begin
				event_code       <= EV_NORMAL;
				avg_weight       <= '0;
				spread_weight    <= '0;
				change_rate      <= '0;
				trend_hundredths <= '0;
				inflow_rate      <= '0;
				usage_rate       <= '0;
				health_tenths    <= 10'd500;
				anomaly_tenths   <= '0;
			end else begin
				event_code       <= ev_c;
				avg_weight       <= mean_q;
				spread_weight    <= 27'(std_w);
				change_rate      <= rate_q;
				trend_hundredths <= trend_c;
				inflow_rate      <= inflow_c;
				usage_rate       <= cons_c;
				health_tenths    <= hsum[14:5];
				anomaly_tenths   <= anom_c;
			end
		end
	end

	assign out_valid = out_valid_q;

	// status back to the controller
	assign sts.clr_done = clr_addr_q == LAST_ADDR;
	assign sts.n_zero   = n_q == '0;
	assign sts.n_multi  = n_q >= CW'(2);
	assign sts.div_busy = div_busy;
	assign sts.sq_busy  = sq_busy;
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule
`default_nettype wire

@@ design/wwse_ctrl.sv @@
// sequencing state machine for the weight window statistics block
`default_nettype none
module wwse_ctrl import wwse_pkg::*; #(
	parameter int RING_DEPTH    = RING_DEPTH_DEF,
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam int WIN = (WINDOW_LENGTH < RING_DEPTH) ? WINDOW_LENGTH : RING_DEPTH;
	localparam int TW  = $clog2(WIN+4);

	state_t        state_q;
	state_t        state_d;
	logic [TW-1:0] cnt_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// walk and drain counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_WALK) begin
			cnt_q <= (cnt_q == TW'(WIN-1)) ? '0 : cnt_q + TW'(1);
		end else if (state_q == ST_DRAIN) begin
			cnt_q <= cnt_q + TW'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (sts.clr_done) state_d = ST_IDLE;
			ST_IDLE:      if (in_valid) state_d = ST_SETUP;
			ST_SETUP:     state_d = ST_WALK;
			ST_WALK:      if (cnt_q == TW'(WIN-1)) state_d = ST_DRAIN;
			ST_DRAIN:     if (cnt_q == TW'(2)) state_d = ST_PREP1;
			ST_PREP1:     state_d = ST_PREP2;
			ST_PREP2:     state_d = sts.n_zero ? ST_FINISH : ST_VAR_GO;
			ST_VAR_GO:    state_d = ST_VAR_WAIT;
			ST_VAR_WAIT:  if (!sts.div_busy) state_d = ST_SQ_GO;
			ST_SQ_GO:     state_d = ST_SQ_WAIT;
			ST_SQ_WAIT:   if (!sts.sq_busy) state_d = ST_MEAN_GO;
			ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
			ST_MEAN_WAIT: if (!sts.div_busy) state_d = sts.n_multi ? ST_RATE_GO : ST_FINISH;
			ST_RATE_GO:   state_d = ST_RATE_WAIT;
			ST_RATE_WAIT: if (!sts.div_busy) state_d = ST_FINISH;
			ST_FINISH:    if (!sts.out_busy) state_d = ST_IDLE;
			default:      state_d = ST_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.op = OP_VAR;
		unique case (state_q)
			ST_CLEAR:     cmd.clr_en = 1'b1;
			ST_IDLE:      cmd.accept = in_valid;
			ST_SETUP:     cmd.walk_start = 1'b1;
			ST_WALK:      cmd.rd_en = 1'b1;
			ST_DRAIN:     ;
			ST_PREP1:     cmd.prep1 = 1'b1;
			ST_PREP2:     cmd.prep2 = 1'b1;
			ST_VAR_GO:    cmd.div_start = 1'b1;
			ST_VAR_WAIT:  ;
			ST_SQ_GO:     cmd.sq_start = 1'b1;
			ST_SQ_WAIT:   ;
			ST_MEAN_GO: begin
				cmd.op = OP_MEAN;
				cmd.div_start = 1'b1;
			end
			ST_MEAN_WAIT: begin
				cmd.op = OP_MEAN;
				cmd.capture = !sts.div_busy;
			end
			ST_RATE_GO: begin
				cmd.op = OP_RATE;
				cmd.div_start = 1'b1;
			end
			ST_RATE_WAIT: begin
				cmd.op = OP_RATE;
				cmd.capture = !sts.div_busy;
			end
			ST_FINISH:    cmd.load_out = !sts.out_busy;
			default:      ;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;

endmodule
`default_nettype wire
